### rtl/ttlkv_pkg.sv
// ttlkv_pkg: operation codes, result status codes and the wrap-safe
// expiry check for the expiring key/value table. No dependencies.
`timescale 1ns / 1ps

package ttlkv_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TTL_W    = 16;
  localparam int unsigned KEYID_W  = 32;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [FUNC_W-1:0] FN_PUT  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_GET  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TICK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TICK    = 3'd6;

  typedef logic [TIME_W-1:0] time_word_t;

  // expired when now is strictly later than expiry, modulo wrap
  function automatic logic is_expired(input time_word_t now, input time_word_t expiry);
    time_word_t d;
    d = now - expiry;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

### rtl/ttl_expiring_key_value_table.sv
// ttl_expiring_key_value_table: put/get/tick key/value table with expiry.
// Valid bits and entry payload live in two synchronous memories.
// Depends on ttlkv_pkg.
`timescale 1ns / 1ps

// Each accepted word (start high while busy low) with a put, get or tick
// func walks all ENTRIES slots of the table memories, one slot per cycle,
// then passes S_FIN and S_WB to its result; an unused func code goes
// straight to S_WB. After reset the block clears every slot of the valid
// memory with busy high. Each result shows for exactly one cycle with
// out_strobe high; the receiver cannot hold it off, so it must take every
// strobed word.
module ttl_expiring_key_value_table #(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ttlkv_pkg::FUNC_W-1:0]      in_func,
  input  logic [ttlkv_pkg::KEYID_W-1:0]     in_key_id,
  input  logic signed [ttlkv_pkg::DATA_W-1:0] in_put_value,
  input  logic [ttlkv_pkg::TTL_W-1:0]       in_ttl_seconds,
  output logic                              out_strobe,
  output logic [ttlkv_pkg::STATUS_W-1:0]    out_status,
  output logic signed [ttlkv_pkg::DATA_W-1:0] out_read_value,
  output logic [ttlkv_pkg::COUNT_W-1:0]     out_occupancy,
  output logic [ttlkv_pkg::COUNT_W-1:0]     out_swept_count
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned DW = ttlkv_pkg::DATA_W;
  localparam int unsigned TW = ttlkv_pkg::TIME_W;
  localparam int unsigned PW = KEY_BITS + DW + TW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // memories
  logic          vmem [ENTRIES];
  logic [PW-1:0] pmem [ENTRIES];
  logic          vq;
  logic [PW-1:0] pq;
  logic [IW-1:0] rd_addr;
  logic          v_we;
  logic [IW-1:0] v_wa;
  logic          v_wd;
  logic          p_we;
  logic [PW-1:0] p_wd;

  // control and item registers
  logic [2:0]                        state_r, state_nxt;
  logic [IW-1:0]                     idx_r, idx_nxt;
  logic                              rdv_r, rdv_nxt;
  logic [IW-1:0]                     rdi_r, rdi_nxt;
  logic [ttlkv_pkg::FUNC_W-1:0]      func_r, func_nxt;
  logic [KEY_BITS-1:0]               key_r, key_nxt;
  logic [DW-1:0]                     val_r, val_nxt;
  logic [ttlkv_pkg::TTL_W-1:0]       ttl_r, ttl_nxt;
  ttlkv_pkg::time_word_t             time_r, time_nxt;
  logic [CW-1:0]                     live_r, live_nxt;
  logic [CW-1:0]                     swept_r, swept_nxt;
  logic                              found_r, found_nxt;
  logic                              free_found_r, free_found_nxt;
  logic [IW-1:0]                     free_idx_r, free_idx_nxt;
  logic [IW-1:0]                     hit_idx_r, hit_idx_nxt;
  logic [DW-1:0]                     hit_data_r, hit_data_nxt;
  ttlkv_pkg::time_word_t             hit_exp_r, hit_exp_nxt;
  logic                              ostb_r, ostb_nxt;
  logic [ttlkv_pkg::STATUS_W-1:0]    ost_r, ost_nxt;
  logic [DW-1:0]                     ordv_r, ordv_nxt;
  logic [ttlkv_pkg::COUNT_W-1:0]     oocc_r, oocc_nxt;
  logic [ttlkv_pkg::COUNT_W-1:0]     oswp_r, oswp_nxt;

  logic [KEY_BITS-1:0]   d_key;
  logic [DW-1:0]         d_data;
  ttlkv_pkg::time_word_t d_exp;
  logic                  d_match;

  assign d_key   = pq[PW-1 -: KEY_BITS];
  assign d_data  = pq[DW+TW-1 -: DW];
  assign d_exp   = pq[TW-1:0];
  assign d_match = vq && (d_key == key_r);

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
    if (p_we) begin
      pmem[free_idx_r] <= p_wd;
    end
    vq <= vmem[rd_addr];
    pq <= pmem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rdv_nxt        = 1'b0;
    rdi_nxt        = rdi_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    ttl_nxt        = ttl_r;
    time_nxt       = time_r;
    live_nxt       = live_r;
    swept_nxt      = swept_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_idx_nxt    = hit_idx_r;
    hit_data_nxt   = hit_data_r;
    hit_exp_nxt    = hit_exp_r;
    ostb_nxt       = 1'b0;
    ost_nxt        = ost_r;
    ordv_nxt       = ordv_r;
    oocc_nxt       = oocc_r;
    oswp_nxt       = oswp_r;
    rd_addr        = idx_r;
    v_we           = 1'b0;
    v_wa           = rdi_r;
    v_wd           = 1'b0;
    p_we           = 1'b0;
    p_wd           = {key_r, val_r, time_r + TW'(ttl_r)};

    // examine the slot read last cycle
    if (rdv_r) begin
      case (func_r)
        ttlkv_pkg::FN_PUT: begin
          if (d_match) begin
            found_nxt = 1'b1;
          end
          if (!vq && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = rdi_r;
          end
        end
        ttlkv_pkg::FN_GET: begin
          if (d_match) begin
            found_nxt    = 1'b1;
            hit_idx_nxt  = rdi_r;
            hit_data_nxt = d_data;
            hit_exp_nxt  = d_exp;
          end
        end
        ttlkv_pkg::FN_TICK: begin
          if (vq && ttlkv_pkg::is_expired(time_r, d_exp)) begin
            v_we      = 1'b1;
            v_wa      = rdi_r;
            v_wd      = 1'b0;
            swept_nxt = swept_r + CW'(1);
            live_nxt  = live_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        v_we    = 1'b1;
        v_wa    = idx_r;
        v_wd    = 1'b0;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          func_nxt       = in_func;
          key_nxt        = KEY_BITS'(in_key_id);
          val_nxt        = in_put_value;
          ttl_nxt        = in_ttl_seconds;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          swept_nxt      = '0;
          idx_nxt        = '0;
          if (in_func == ttlkv_pkg::FN_TICK) begin
            time_nxt = time_r + TW'(1);
          end
          if (in_func == ttlkv_pkg::FN_PUT || in_func == ttlkv_pkg::FN_GET ||
              in_func == ttlkv_pkg::FN_TICK) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_WB;
          end
        end
      end
      S_SCAN: begin
        rdv_nxt = 1'b1;
        rdi_nxt = idx_r;
        idx_nxt = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        ost_nxt  = ttlkv_pkg::ST_MISS;
        ordv_nxt = '0;
        oswp_nxt = '0;
        case (func_r)
          ttlkv_pkg::FN_PUT: begin
            if (found_r) begin
              ost_nxt = ttlkv_pkg::ST_DUP;
            end else if (!free_found_r) begin
              ost_nxt = ttlkv_pkg::ST_FULL;
            end else begin
              v_we     = 1'b1;
              v_wa     = free_idx_r;
              v_wd     = 1'b1;
              p_we     = 1'b1;
              live_nxt = live_r + CW'(1);
              ost_nxt  = ttlkv_pkg::ST_STORED;
            end
          end
          ttlkv_pkg::FN_GET: begin
            if (!found_r) begin
              ost_nxt = ttlkv_pkg::ST_MISS;
            end else if (ttlkv_pkg::is_expired(time_r, hit_exp_r)) begin
              v_we     = 1'b1;
              v_wa     = hit_idx_r;
              v_wd     = 1'b0;
              live_nxt = live_r - CW'(1);
              ost_nxt  = ttlkv_pkg::ST_EXPIRED;
            end else begin
              ordv_nxt = hit_data_r;
              ost_nxt  = ttlkv_pkg::ST_HIT;
            end
          end
          ttlkv_pkg::FN_TICK: begin
            ost_nxt  = ttlkv_pkg::ST_TICK;
            oswp_nxt = ttlkv_pkg::COUNT_W'(swept_r);
          end
          default: begin
          end
        endcase
        oocc_nxt  = ttlkv_pkg::COUNT_W'(live_nxt);
        ostb_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
      rdv_r   <= 1'b0;
      time_r  <= '0;
      live_r  <= '0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rdv_r   <= rdv_nxt;
      time_r  <= time_nxt;
      live_r  <= live_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdi_r        <= rdi_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    ttl_r        <= ttl_nxt;
    swept_r      <= swept_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_data_r   <= hit_data_nxt;
    hit_exp_r    <= hit_exp_nxt;
    ost_r        <= ost_nxt;
    ordv_r       <= ordv_nxt;
    oocc_r       <= oocc_nxt;
    oswp_r       <= oswp_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = ostb_r;
  assign out_status      = ost_r;
  assign out_read_value  = ordv_r;
  assign out_occupancy   = oocc_r;
  assign out_swept_count = oswp_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while table busy");

  a_wb_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> out_strobe)
    else $error("write-back without result");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(ENTRIES))
    else $error("occupancy exceeds table size");

  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == ttlkv_pkg::FN_TICK) |=> time_r == $past(time_r) + TW'(1))
    else $error("tick did not advance time");

endmodule
